// ----- hw/rtl/a2r_pkg.sv -----
// shared types, constants and symbol tables for the arabic to roman encoder
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package a2r_pkg;

  localparam int ValueW     = 12;
  localparam int SymW       = 8;
  localparam int NumWeights = 13;
  localparam int IdxW       = $clog2(NumWeights);
  localparam int QDepth     = 2;
  localparam int QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam logic [ValueW-1:0] MaxValue = ValueW'(3999);

  localparam logic [SymW-1:0] CharNone = 8'h00;
  localparam logic [SymW-1:0] CharM    = 8'h4d;
  localparam logic [SymW-1:0] CharD    = 8'h44;
  localparam logic [SymW-1:0] CharC    = 8'h43;
  localparam logic [SymW-1:0] CharL    = 8'h4c;
  localparam logic [SymW-1:0] CharX    = 8'h58;
  localparam logic [SymW-1:0] CharV    = 8'h56;
  localparam logic [SymW-1:0] CharI    = 8'h49;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEmpty = 2'd1,
    StatusRange = 2'd2
  } status_e;

  // classified item handed from the front to the back
  typedef struct packed {
    status_e           kind;
    logic [ValueW-1:0] value;
  } item_t;

  function automatic logic [ValueW-1:0] weight(input logic [IdxW-1:0] idx);
    logic [ValueW-1:0] w;
    case (idx)
      4'd0:    w = ValueW'(1000);
      4'd1:    w = ValueW'(900);
      4'd2:    w = ValueW'(500);
      4'd3:    w = ValueW'(400);
      4'd4:    w = ValueW'(100);
      4'd5:    w = ValueW'(90);
      4'd6:    w = ValueW'(50);
      4'd7:    w = ValueW'(40);
      4'd8:    w = ValueW'(10);
      4'd9:    w = ValueW'(9);
      4'd10:   w = ValueW'(5);
      4'd11:   w = ValueW'(4);
      default: w = ValueW'(1);
    endcase
    return w;
  endfunction

  function automatic logic [SymW-1:0] lead_sym(input logic [IdxW-1:0] idx);
    logic [SymW-1:0] s;
    case (idx)
      4'd0:    s = CharM;
      4'd1:    s = CharC;
      4'd2:    s = CharD;
      4'd3:    s = CharC;
      4'd4:    s = CharC;
      4'd5:    s = CharX;
      4'd6:    s = CharL;
      4'd7:    s = CharX;
      4'd8:    s = CharX;
      4'd9:    s = CharI;
      4'd10:   s = CharV;
      default: s = CharI;
    endcase
    return s;
  endfunction

  // second letter of a subtractive pair, none for single letters
  function automatic logic [SymW-1:0] tail_sym(input logic [IdxW-1:0] idx);
    logic [SymW-1:0] s;
    case (idx)
      4'd1:    s = CharM;
      4'd3:    s = CharD;
      4'd5:    s = CharC;
      4'd7:    s = CharL;
      4'd9:    s = CharX;
      4'd11:   s = CharV;
      default: s = CharNone;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/arabic_to_roman_encoder.sv -----
// top level of the arabic to roman encoder: front, item queue and back end
// depends on a2r_pkg, a2r_front, a2r_queue, a2r_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one 12-bit number per input beat and streams its Roman numeral as ASCII
// letters, most significant first, one letter per output beat, tlast on the
// final letter. Zero gives a single beat with status empty, values above 3999 a
// single beat with status out of range, both with symbol zero. An ok number
// occupies the back end while it is loaded and while each of its letters is
// sent, up to the fifteen letters of 3888; a special case goes out straight
// from the queue with no load. A two-entry queue after the input classifier
// lets new beats in while a numeral is still streaming. The output stage is a
// register; a stalled sink holds the back end, and the input on a full queue.

module arabic_to_roman_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [11:0] value, [15:12] zero
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] symbol
  output logic             m_axis_tlast_o,   // last letter of the numeral
  output logic [1:0]       m_axis_tuser_o    // [1:0] status
);

  // front to queue
  logic           q_push;
  logic           q_full;
  a2r_pkg::item_t q_in_item;
  // queue to back
  logic           q_pop;
  logic           q_valid;
  a2r_pkg::item_t q_out_item;
  // back output status, as enum
  a2r_pkg::status_e out_status;

  // classify each beat on the way in
  a2r_front u_front (
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_value_i (s_axis_tdata_i[a2r_pkg::ValueW-1:0]),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in_item)
  );

  // decouples the classifier from the letter sequencer
  a2r_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out_item),
    .valid_o (q_valid)
  );

  // greedy letter generation, one letter a cycle while a numeral is being spelled, unless the output stalls
  a2r_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_sym_o    (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (out_status)
  );

  assign m_axis_tuser_o = out_status;

endmodule

`default_nettype wire

// ----- hw/rtl/a2r_front.sv -----
// front end: takes input beats and classifies them as empty, out of range or ok
// depends on a2r_pkg
`timescale 1ns / 1ps
`default_nettype none

module a2r_front (
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [a2r_pkg::ValueW-1:0] in_value_i,
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output a2r_pkg::item_t                  q_item_o
);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.value = in_value_i;
    if (in_value_i == '0) begin
      q_item_o.kind = a2r_pkg::StatusEmpty;
    end else if (in_value_i > a2r_pkg::MaxValue) begin
      q_item_o.kind = a2r_pkg::StatusRange;
    end else begin
      q_item_o.kind = a2r_pkg::StatusOk;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/a2r_queue.sv -----
// short flip-flop queue of classified items between front and back
// depends on a2r_pkg
`timescale 1ns / 1ps
`default_nettype none

module a2r_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire a2r_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output a2r_pkg::item_t      item_o,
  output logic                valid_o
);

  a2r_pkg::item_t                   mem_q [a2r_pkg::QDepth];
  logic [a2r_pkg::QPtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [a2r_pkg::QPtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [a2r_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == a2r_pkg::QCntW'(a2r_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == a2r_pkg::QPtrW'(a2r_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == a2r_pkg::QPtrW'(a2r_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/a2r_back.sv -----
// back end: greedy letter sequencer with a registered output stage
// depends on a2r_pkg
`timescale 1ns / 1ps
`default_nettype none

module a2r_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire a2r_pkg::item_t           q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [a2r_pkg::SymW-1:0]      out_sym_o,
  output logic                          out_last_o,
  output a2r_pkg::status_e              out_status_o
);

  logic                            busy_q, busy_d;
  logic                            tail_q, tail_d;
  logic [a2r_pkg::IdxW-1:0]        idx_q, idx_d;
  logic [a2r_pkg::ValueW-1:0]      n_q, n_d;
  logic                            out_valid_q, out_valid_d;
  logic [a2r_pkg::SymW-1:0]        out_sym_q, out_sym_d;
  logic                            out_last_q, out_last_d;
  a2r_pkg::status_e                out_status_q, out_status_d;

  logic                            advance;
  logic [a2r_pkg::IdxW-1:0]        sel;
  logic [a2r_pkg::ValueW-1:0]      n_rem;

  // largest weight that still fits the remainder
  always_comb begin
    sel = a2r_pkg::IdxW'(a2r_pkg::NumWeights - 1);
    for (int i = a2r_pkg::NumWeights - 1; i >= 0; i--) begin
      if (n_q >= a2r_pkg::weight(a2r_pkg::IdxW'(i))) begin
        sel = a2r_pkg::IdxW'(i);
      end
    end
  end

  assign n_rem   = n_q - a2r_pkg::weight(sel);
  assign advance = !out_valid_q || out_ready_i;
  assign q_pop_o = advance && !busy_q && q_valid_i;

  always_comb begin
    busy_d       = busy_q;
    tail_d       = tail_q;
    idx_d        = idx_q;
    n_d          = n_q;
    out_valid_d  = out_valid_q;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (advance) begin
      out_valid_d = 1'b0;
      if (busy_q) begin
        out_valid_d  = 1'b1;
        out_status_d = a2r_pkg::StatusOk;
        if (tail_q) begin
          out_sym_d  = a2r_pkg::tail_sym(idx_q);
          out_last_d = (n_q == '0);
          tail_d     = 1'b0;
          busy_d     = (n_q != '0);
        end else begin
          out_sym_d = a2r_pkg::lead_sym(sel);
          n_d       = n_rem;
          if (a2r_pkg::tail_sym(sel) != a2r_pkg::CharNone) begin
            tail_d     = 1'b1;
            idx_d      = sel;
            out_last_d = 1'b0;
          end else begin
            out_last_d = (n_rem == '0);
            busy_d     = (n_rem != '0);
          end
        end
      end else if (q_valid_i) begin
        if (q_item_i.kind != a2r_pkg::StatusOk) begin
          out_valid_d  = 1'b1;
          out_sym_d    = a2r_pkg::CharNone;
          out_last_d   = 1'b1;
          out_status_d = q_item_i.kind;
        end else begin
          busy_d = 1'b1;
          tail_d = 1'b0;
          n_d    = q_item_i.value;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    n_q          <= n_d;
    out_sym_q    <= out_sym_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_sym_o    = out_sym_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/a2r_checker.sv -----
// port-level checks for the arabic to roman encoder, bound to the top level
// depends on a2r_pkg and arabic_to_roman_encoder
`timescale 1ns / 1ps
`default_nettype none

module a2r_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [7:0]  m_axis_tdata_o,
  input wire logic        m_axis_tlast_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // a stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("output beat changed while stalled");

  // empty and out of range results are single beats with no letter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != a2r_pkg::StatusOk) |->
      m_axis_tlast_o && (m_axis_tdata_o == a2r_pkg::CharNone))
    else $error("special result not a lone empty beat");

  // ok beats carry a roman letter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == a2r_pkg::StatusOk) |->
      (m_axis_tdata_o == a2r_pkg::CharM) || (m_axis_tdata_o == a2r_pkg::CharD) ||
      (m_axis_tdata_o == a2r_pkg::CharC) || (m_axis_tdata_o == a2r_pkg::CharL) ||
      (m_axis_tdata_o == a2r_pkg::CharX) || (m_axis_tdata_o == a2r_pkg::CharV) ||
      (m_axis_tdata_o == a2r_pkg::CharI))
    else $error("ok beat without a roman letter");

  // a special result never lands in the middle of a numeral
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o ##1 m_axis_tvalid_o |->
      (m_axis_tuser_o == a2r_pkg::StatusOk))
    else $error("special result inside a numeral");

endmodule

bind arabic_to_roman_encoder a2r_checker u_a2r_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// self-checking bench for arabic_to_roman_encoder: spells every accepted number
// into its expected letter beats and compares them with the output stream
// depends on a2r_pkg and the encoder rtl
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandItems  = 430;

  // one expected output beat
  typedef struct {
    logic [7:0]        symbol;
    logic              last;
    a2r_pkg::status_e  status;
  } letter_t;

  // one number waiting to be sent
  typedef struct {
    logic [11:0] value;
    logic        drain;   // hold it back until every letter so far has come out
    logic        steady;  // no idling on either side around this one
  } number_t;

  // greedy steps, largest first, with the one or two letters each stands for
  localparam int unsigned StepVal [13] = '{1000, 900, 500, 400, 100, 90, 50, 40,
                                           10, 9, 5, 4, 1};
  localparam logic [7:0] LeadChar [13] = '{
    a2r_pkg::CharM, a2r_pkg::CharC, a2r_pkg::CharD, a2r_pkg::CharC, a2r_pkg::CharC,
    a2r_pkg::CharX, a2r_pkg::CharL, a2r_pkg::CharX, a2r_pkg::CharX, a2r_pkg::CharI,
    a2r_pkg::CharV, a2r_pkg::CharI, a2r_pkg::CharI};
  localparam logic [7:0] TailChar [13] = '{
    a2r_pkg::CharNone, a2r_pkg::CharM, a2r_pkg::CharNone, a2r_pkg::CharD,
    a2r_pkg::CharNone, a2r_pkg::CharC, a2r_pkg::CharNone, a2r_pkg::CharL,
    a2r_pkg::CharNone, a2r_pkg::CharX, a2r_pkg::CharNone, a2r_pkg::CharV,
    a2r_pkg::CharNone};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        steady = 1'b0;

  number_t     numbers_to_send [$];
  letter_t     letters_due [$];
  int unsigned numbers_total = 0;
  int unsigned numbers_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  always #5 clk_i = ~clk_i;

  arabic_to_roman_encoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [11:0] value, [15:12] zero
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [7:0] symbol
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)    // [1:0] status
  );

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void push_letter(input logic [7:0] sym, input a2r_pkg::status_e st);
    letter_t ltr;
    ltr.symbol = sym;
    ltr.last   = 1'b0;
    ltr.status = st;
    letters_due.push_back(ltr);
  endfunction

  // expected beats for one accepted number
  function automatic void spell_numeral(input logic [11:0] value);
    int unsigned rest;
    rest = value;
    if (rest == 0) begin
      push_letter(a2r_pkg::CharNone, a2r_pkg::StatusEmpty);
    end else if (rest > a2r_pkg::MaxValue) begin
      push_letter(a2r_pkg::CharNone, a2r_pkg::StatusRange);
    end else begin
      for (int k = 0; k < 13; k++) begin
        while (rest >= StepVal[k]) begin
          push_letter(LeadChar[k], a2r_pkg::StatusOk);
          if (TailChar[k] != a2r_pkg::CharNone) push_letter(TailChar[k], a2r_pkg::StatusOk);
          rest -= StepVal[k];
        end
      end
    end
    letters_due[$].last = 1'b1;
  endfunction

  function automatic logic [11:0] random_number();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return 12'd0;
    if (pick < 12) return 12'($urandom_range(4000, 4095));
    if (pick < 20) return 12'($urandom_range(0, 4095));
    if (pick < 35) return 12'($urandom_range(1, 99));
    if (pick < 45) return 12'($urandom_range(3000, 3999));
    if (pick < 48) return 12'd3888;
    return 12'($urandom_range(1, 3999));
  endfunction

  function automatic void queue_number(input logic [11:0] value, input logic drain,
                                       input logic stdy);
    number_t num;
    num.value  = value;
    num.drain  = drain;
    num.steady = stdy;
    numbers_to_send.push_back(num);
    numbers_total++;
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d: %s expected 'h%0h got 'h%0h", mismatches, what, want, got);
  endfunction

  // sender: presents queued numbers with random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic        holding;
    number_t     nxt;
    int unsigned gap_left;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      steady   <= 1'b0;
      gap_left = 0;
    end else begin
      holding = s_tvalid;
      if (s_tvalid && s_tready) begin
        spell_numeral(s_tdata[11:0]);
        numbers_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (numbers_to_send.size() != 0 &&
                     !(numbers_to_send[0].drain && letters_due.size() != 0)) begin
          nxt = numbers_to_send.pop_front();
          s_tdata <= {4'b0000, nxt.value};
          steady  <= nxt.steady;
          holding = 1'b1;
          gap_left = (nxt.steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        end
      end
      s_tvalid <= holding;
    end
  end

  // receiver: random back-pressure, checks every letter beat against the oldest due
  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    letter_t     want;
    int unsigned stall_left;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (letters_due.size() == 0) begin
          note_mismatch("beat with nothing due, symbol", 0, m_tdata);
        end else begin
          want = letters_due.pop_front();
          if (m_tdata !== want.symbol) note_mismatch("symbol", want.symbol, m_tdata);
          if (m_tlast !== want.last)   note_mismatch("last", want.last, m_tlast);
          if (m_tuser !== want.status) note_mismatch("status", want.status, m_tuser);
        end
      end
      if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[arabic_to_roman_encoder] ERROR");
      $finish;
    end
  end

  initial begin
    // directed: both special cases, range edges, every subtractive pair,
    // the longest numeral and alternating bit patterns
    queue_number(12'd0, 1'b0, 1'b0);
    queue_number(12'd1, 1'b0, 1'b0);
    queue_number(12'd4, 1'b0, 1'b0);
    queue_number(12'd5, 1'b0, 1'b0);
    queue_number(12'd9, 1'b0, 1'b0);
    queue_number(12'd10, 1'b0, 1'b0);
    queue_number(12'd40, 1'b0, 1'b0);
    queue_number(12'd49, 1'b0, 1'b0);
    queue_number(12'd90, 1'b0, 1'b0);
    queue_number(12'd99, 1'b0, 1'b0);
    queue_number(12'd400, 1'b0, 1'b0);
    queue_number(12'd444, 1'b0, 1'b0);
    queue_number(12'd900, 1'b0, 1'b0);
    queue_number(12'd999, 1'b0, 1'b0);
    queue_number(12'd1000, 1'b0, 1'b0);
    queue_number(12'd1994, 1'b0, 1'b0);
    queue_number(12'd2048, 1'b0, 1'b0);
    queue_number(12'd3888, 1'b0, 1'b0);
    queue_number(12'd3999, 1'b0, 1'b0);
    queue_number(12'd4000, 1'b0, 1'b0);
    queue_number(12'd4095, 1'b0, 1'b0);
    queue_number(12'haaa, 1'b0, 1'b0);
    queue_number(12'h555, 1'b0, 1'b0);

    // random part: a few numbers wait for the output to drain, and one
    // stretch runs with no idling at all
    for (int unsigned n = 0; n < RandItems; n++)
      queue_number(random_number(), (n == 0 || n == 120 || n == 260),
                   (n >= 300 && n < 340));

    // release reset away from the active edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (numbers_taken != numbers_total || letters_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    if (mismatches == 0 && letters_due.size() == 0) begin
      $display("[arabic_to_roman_encoder] OK");
    end else begin
      $display("[arabic_to_roman_encoder] ERROR");
    end
    $finish;
  end

endmodule
